// File: rtl/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants for the RV32I integer execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

    localparam int XLEN        = 32;
    localparam int IDX_W       = 5;
    localparam int FUNC_W      = 5;
    localparam int NUM_REGS_DEF = 32;

    localparam logic [XLEN-1:0] LUI_MASK  = 32'hFFFF_F000;
    localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;
    localparam logic [XLEN-1:0] PC_STEP   = 32'd4;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ADD   = 5'd0;
    localparam logic [FUNC_W-1:0] FN_ADDI  = 5'd1;
    localparam logic [FUNC_W-1:0] FN_SUB   = 5'd2;
    localparam logic [FUNC_W-1:0] FN_LUI   = 5'd3;
    localparam logic [FUNC_W-1:0] FN_XOR   = 5'd4;
    localparam logic [FUNC_W-1:0] FN_XORI  = 5'd5;
    localparam logic [FUNC_W-1:0] FN_OR    = 5'd6;
    localparam logic [FUNC_W-1:0] FN_ORI   = 5'd7;
    localparam logic [FUNC_W-1:0] FN_AND   = 5'd8;
    localparam logic [FUNC_W-1:0] FN_ANDI  = 5'd9;
    localparam logic [FUNC_W-1:0] FN_SLL   = 5'd10;
    localparam logic [FUNC_W-1:0] FN_SRL   = 5'd11;
    localparam logic [FUNC_W-1:0] FN_SRA   = 5'd12;
    localparam logic [FUNC_W-1:0] FN_SLT   = 5'd13;
    localparam logic [FUNC_W-1:0] FN_SLTI  = 5'd14;
    localparam logic [FUNC_W-1:0] FN_SLTU  = 5'd15;
    localparam logic [FUNC_W-1:0] FN_SLTIU = 5'd16;
    localparam logic [FUNC_W-1:0] FN_BEQ   = 5'd17;
    localparam logic [FUNC_W-1:0] FN_BNE   = 5'd18;
    localparam logic [FUNC_W-1:0] FN_BLT   = 5'd19;
    localparam logic [FUNC_W-1:0] FN_BLTU  = 5'd20;
    localparam logic [FUNC_W-1:0] FN_BGE   = 5'd21;
    localparam logic [FUNC_W-1:0] FN_BGEU  = 5'd22;
    localparam logic [FUNC_W-1:0] FN_JAL   = 5'd23;
    localparam logic [FUNC_W-1:0] FN_JALR  = 5'd24;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [IDX_W-1:0]        dest_reg;
        logic [IDX_W-1:0]        src1_reg;
        logic [IDX_W-1:0]        src2_reg;
        logic signed [XLEN-1:0]  immediate;
    } t_ex_req;

    typedef struct packed {
        logic [XLEN-1:0] write_value;
        logic            wrote_reg;
        logic            branch_taken;
        logic [XLEN-1:0] new_pc;
    } t_ex_rsp;

endpackage

// File: rtl/rvex_regfile.sv
// ----------------------------------------------------------------------------
// rvex_regfile
// Register file memory: two registered read ports, one write port, and a
// valid bit per entry so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module rvex_regfile #(
    parameter int NUM_REGS = rvex_pkg::NUM_REGS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_rd_en,
    input  logic [$clog2(NUM_REGS)-1:0]              i_rd_addr1,
    input  logic [$clog2(NUM_REGS)-1:0]              i_rd_addr2,
    output logic [rvex_pkg::XLEN-1:0]                o_rd_data1,
    output logic [rvex_pkg::XLEN-1:0]                o_rd_data2,
    input  logic                                     i_wr_en,
    input  logic [$clog2(NUM_REGS)-1:0]              i_wr_addr,
    input  logic [rvex_pkg::XLEN-1:0]                i_wr_data
);

    localparam int AW    = $clog2(NUM_REGS);
    localparam int DEPTH = 1 << AW;

    logic [rvex_pkg::XLEN-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]          r_vld;
    logic [rvex_pkg::XLEN-1:0] r_q1;
    logic [rvex_pkg::XLEN-1:0] r_q2;
    logic                      r_v1;
    logic                      r_v2;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q1 <= r_mem[i_rd_addr1];
            r_q2 <= r_mem[i_rd_addr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_v1 <= r_vld[i_rd_addr1];
                r_v2 <= r_vld[i_rd_addr2];
            end
        end
    end

    assign o_rd_data1 = r_v1 ? r_q1 : '0;
    assign o_rd_data2 = r_v2 ? r_q2 : '0;

endmodule

// File: rtl/rvex_alu.sv
// ----------------------------------------------------------------------------
// rvex_alu
// Execute logic: ALU result, branch decision, next program counter.
// ----------------------------------------------------------------------------
module rvex_alu #(
    parameter int NUM_REGS = rvex_pkg::NUM_REGS_DEF
) (
    input  rvex_pkg::t_ex_req            i_req,
    input  logic [rvex_pkg::XLEN-1:0]    i_a,
    input  logic [rvex_pkg::XLEN-1:0]    i_b,
    input  logic [rvex_pkg::XLEN-1:0]    i_pc,
    output rvex_pkg::t_ex_rsp            o_rsp
);

    localparam logic [rvex_pkg::IDX_W:0] NREG = (rvex_pkg::IDX_W + 1)'(NUM_REGS);

    logic [rvex_pkg::XLEN-1:0] imm;
    logic [rvex_pkg::XLEN-1:0] link;
    logic [4:0]                shamt;
    logic                      lt_s;
    logic                      lt_u;
    logic                      lti_s;
    logic                      lti_u;
    logic                      dest_ok;
    logic [rvex_pkg::XLEN-1:0] val;
    logic                      writes;
    logic                      taken;
    logic [rvex_pkg::XLEN-1:0] next;

    assign imm   = i_req.immediate;
    assign link  = i_pc + rvex_pkg::PC_STEP;
    assign shamt = i_b[4:0];
    assign lt_s  = $signed(i_a) < $signed(i_b);
    assign lt_u  = i_a < i_b;
    assign lti_s = $signed(i_a) < $signed(imm);
    assign lti_u = i_a < imm;

    assign dest_ok = (i_req.dest_reg != '0) && ({1'b0, i_req.dest_reg} < NREG);

    always_comb begin
        val    = '0;
        writes = 1'b0;
        taken  = 1'b0;
        next   = link;
        case (i_req.func)
            rvex_pkg::FN_ADD:   begin val = i_a + i_b;             writes = 1'b1; end
            rvex_pkg::FN_ADDI:  begin val = i_a + imm;             writes = 1'b1; end
            rvex_pkg::FN_SUB:   begin val = i_a - i_b;             writes = 1'b1; end
            rvex_pkg::FN_LUI:   begin val = imm & rvex_pkg::LUI_MASK; writes = 1'b1; end
            rvex_pkg::FN_XOR:   begin val = i_a ^ i_b;             writes = 1'b1; end
            rvex_pkg::FN_XORI:  begin val = i_a ^ imm;             writes = 1'b1; end
            rvex_pkg::FN_OR:    begin val = i_a | i_b;             writes = 1'b1; end
            rvex_pkg::FN_ORI:   begin val = i_a | imm;             writes = 1'b1; end
            rvex_pkg::FN_AND:   begin val = i_a & i_b;             writes = 1'b1; end
            rvex_pkg::FN_ANDI:  begin val = i_a & imm;             writes = 1'b1; end
            rvex_pkg::FN_SLL:   begin val = i_a << shamt;          writes = 1'b1; end
            rvex_pkg::FN_SRL:   begin val = i_a >> shamt;          writes = 1'b1; end
            rvex_pkg::FN_SRA:   begin val = $unsigned($signed(i_a) >>> shamt); writes = 1'b1; end
            rvex_pkg::FN_SLT:   begin val = {31'd0, lt_s};         writes = 1'b1; end
            rvex_pkg::FN_SLTI:  begin val = {31'd0, lti_s};        writes = 1'b1; end
            rvex_pkg::FN_SLTU:  begin val = {31'd0, lt_u};         writes = 1'b1; end
            rvex_pkg::FN_SLTIU: begin val = {31'd0, lti_u};        writes = 1'b1; end
            rvex_pkg::FN_BEQ:   taken = (i_a == i_b);
            rvex_pkg::FN_BNE:   taken = (i_a != i_b);
            rvex_pkg::FN_BLT:   taken = lt_s;
            rvex_pkg::FN_BLTU:  taken = lt_u;
            rvex_pkg::FN_BGE:   taken = !lt_s;
            rvex_pkg::FN_BGEU:  taken = !lt_u;
            rvex_pkg::FN_JAL: begin
                val    = link;
                writes = 1'b1;
                taken  = 1'b1;
                next   = i_pc + {imm[rvex_pkg::XLEN-2:0], 1'b0};
            end
            rvex_pkg::FN_JALR: begin
                val    = link;
                writes = 1'b1;
                taken  = 1'b1;
                next   = (i_a + imm) & rvex_pkg::JALR_MASK;
            end
            default: ;
        endcase
        // Conditional branches land on PC plus the immediate.
        if (taken && (i_req.func != rvex_pkg::FN_JAL) && (i_req.func != rvex_pkg::FN_JALR)) begin
            next = i_pc + imm;
        end
        if (!(writes && dest_ok)) begin
            writes = 1'b0;
            val    = '0;
        end
    end

    assign o_rsp.write_value  = val;
    assign o_rsp.wrote_reg    = writes;
    assign o_rsp.branch_taken = taken;
    assign o_rsp.new_pc       = next;

endmodule

// File: rtl/rv32i_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_unit
// RV32I integer ALU, branch and jump execution with register file and PC.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_req) as decoded instructions; one response per request leaves on the
// output channel (o_out_valid / i_out_ready, payload o_out_rsp) in order.
// At the edge that accepts a request, the register file memory is read at
// both source addresses. In the following cycle the operands are available
// and the operation executes; at the edge where the output register is empty
// or being emptied, the result is written back, the PC is updated and the
// response is loaded into the output register, which raises o_out_valid.
// The response is taken at an edge where o_out_valid and i_out_ready are high.
// Throughput is one request per cycle while the receiver does not stall.
// The write of the previous request lands in the memory at the same edge as
// the next read, so that value is forwarded from a bypass register instead.
// Reset clears the PC, the pipeline valids and the valid bit of every
// register entry, so all registers read as zero without a clearing pass.
// When the receiver stalls, the response holds in the output register and
// one more request can be accepted and wait with its operands read.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_unit #(
    parameter int NUM_REGS = rvex_pkg::NUM_REGS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rvex_pkg::t_ex_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rvex_pkg::t_ex_rsp o_out_rsp
);

    localparam int AW = $clog2(NUM_REGS);
    localparam logic [rvex_pkg::IDX_W:0] NREG = (rvex_pkg::IDX_W + 1)'(NUM_REGS);

    logic                        r_s1_valid;
    rvex_pkg::t_ex_req           r_s1_req;
    logic                        r_byp_vld;
    logic [rvex_pkg::IDX_W-1:0]  r_byp_addr;
    logic [rvex_pkg::XLEN-1:0]   r_byp_val;
    logic [rvex_pkg::XLEN-1:0]   r_pc;
    logic                        r_out_valid;
    rvex_pkg::t_ex_rsp           r_out_rsp;

    logic                        in_acc;
    logic                        s1_adv;
    logic                        wr_en;
    logic [rvex_pkg::XLEN-1:0]   rd_data1;
    logic [rvex_pkg::XLEN-1:0]   rd_data2;
    logic                        zero1;
    logic                        zero2;
    logic [rvex_pkg::XLEN-1:0]   opnd_a;
    logic [rvex_pkg::XLEN-1:0]   opnd_b;
    rvex_pkg::t_ex_rsp           res;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = s1_adv && res.wrote_reg;

    rvex_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_addr1 (i_in_req.src1_reg[AW-1:0]),
        .i_rd_addr2 (i_in_req.src2_reg[AW-1:0]),
        .o_rd_data1 (rd_data1),
        .o_rd_data2 (rd_data2),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_s1_req.dest_reg[AW-1:0]),
        .i_wr_data  (res.write_value)
    );

    // Register zero and indexes beyond the file read as zero.
    assign zero1 = (r_s1_req.src1_reg == '0) || ({1'b0, r_s1_req.src1_reg} >= NREG);
    assign zero2 = (r_s1_req.src2_reg == '0) || ({1'b0, r_s1_req.src2_reg} >= NREG);

    always_comb begin
        if (zero1) begin
            opnd_a = '0;
        end else if (r_byp_vld && (r_byp_addr == r_s1_req.src1_reg)) begin
            opnd_a = r_byp_val;
        end else begin
            opnd_a = rd_data1;
        end
        if (zero2) begin
            opnd_b = '0;
        end else if (r_byp_vld && (r_byp_addr == r_s1_req.src2_reg)) begin
            opnd_b = r_byp_val;
        end else begin
            opnd_b = rd_data2;
        end
    end

    rvex_alu #(
        .NUM_REGS (NUM_REGS)
    ) u_alu (
        .i_req (r_s1_req),
        .i_a   (opnd_a),
        .i_b   (opnd_b),
        .i_pc  (r_pc),
        .o_rsp (res)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req   <= i_in_req;
            r_byp_addr <= r_s1_req.dest_reg;
            r_byp_val  <= res.write_value;
        end
        if (s1_adv) begin
            r_out_rsp <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_vld   <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                // Remember the write that lands at the same edge as this read.
                r_byp_vld  <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_pc        <= res.new_pc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// File: tb/rv32i_integer_execute_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_integer_execute_unit_test
// Self-checking bench for the RV32I integer execute unit. A shadow copy of
// the register file and PC predicts every response; a short directed program
// hits each operation and corner case, then randomized instruction streams
// run with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_unit_test;

    localparam int XLEN   = rvex_pkg::XLEN;
    localparam int IDX_W  = rvex_pkg::IDX_W;
    localparam int FUNC_W = rvex_pkg::FUNC_W;

    // Highest operation code; codes above the jump and link register one do nothing.
    localparam logic [FUNC_W-1:0] FN_UNUSED_LAST = 5'd31;

    localparam int RANDOM_REQS  = 1600;
    localparam int QUIET_FROM   = 1400;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;

    class exec_scoreboard;
        logic [XLEN-1:0]   arch_regs [rvex_pkg::NUM_REGS_DEF];
        logic [XLEN-1:0]   arch_pc;
        rvex_pkg::t_ex_rsp expected_rsp_q [$];
        int unsigned       mismatches;

        function new();
            foreach (arch_regs[i]) arch_regs[i] = '0;
            arch_pc    = '0;
            mismatches = 0;
        endfunction

        function logic [XLEN-1:0] read_reg(logic [IDX_W-1:0] idx);
            if (idx == '0 || idx >= rvex_pkg::NUM_REGS_DEF) return '0;
            return arch_regs[idx];
        endfunction

        // Executes one instruction on the shadow state and returns its response.
        function rvex_pkg::t_ex_rsp execute_instr(rvex_pkg::t_ex_req req);
            logic [XLEN-1:0]        a;
            logic [XLEN-1:0]        b;
            logic [XLEN-1:0]        imm;
            logic signed [XLEN-1:0] sa;
            logic [XLEN-1:0]        val;
            logic [XLEN-1:0]        nxt;
            logic                   writes;
            logic                   taken;
            logic                   is_branch;
            logic                   cond;
            rvex_pkg::t_ex_rsp      rsp;
            a         = read_reg(req.src1_reg);
            b         = read_reg(req.src2_reg);
            imm       = req.immediate;
            sa        = a;
            val       = '0;
            nxt       = arch_pc + rvex_pkg::PC_STEP;
            writes    = 1'b0;
            taken     = 1'b0;
            is_branch = 1'b0;
            cond      = 1'b0;
            case (req.func)
                rvex_pkg::FN_ADD:   begin val = a + b;   writes = 1'b1; end
                rvex_pkg::FN_ADDI:  begin val = a + imm; writes = 1'b1; end
                rvex_pkg::FN_SUB:   begin val = a - b;   writes = 1'b1; end
                rvex_pkg::FN_LUI:   begin val = imm & rvex_pkg::LUI_MASK; writes = 1'b1; end
                rvex_pkg::FN_XOR:   begin val = a ^ b;   writes = 1'b1; end
                rvex_pkg::FN_XORI:  begin val = a ^ imm; writes = 1'b1; end
                rvex_pkg::FN_OR:    begin val = a | b;   writes = 1'b1; end
                rvex_pkg::FN_ORI:   begin val = a | imm; writes = 1'b1; end
                rvex_pkg::FN_AND:   begin val = a & b;   writes = 1'b1; end
                rvex_pkg::FN_ANDI:  begin val = a & imm; writes = 1'b1; end
                rvex_pkg::FN_SLL:   begin val = a << b[4:0];   writes = 1'b1; end
                rvex_pkg::FN_SRL:   begin val = a >> b[4:0];   writes = 1'b1; end
                rvex_pkg::FN_SRA:   begin val = sa >>> b[4:0]; writes = 1'b1; end
                rvex_pkg::FN_SLT:   begin
                    val = {31'b0, $signed(a) < $signed(b)};   writes = 1'b1;
                end
                rvex_pkg::FN_SLTI:  begin
                    val = {31'b0, $signed(a) < $signed(imm)}; writes = 1'b1;
                end
                rvex_pkg::FN_SLTU:  begin val = {31'b0, a < b};   writes = 1'b1; end
                rvex_pkg::FN_SLTIU: begin val = {31'b0, a < imm}; writes = 1'b1; end
                rvex_pkg::FN_BEQ:   begin is_branch = 1'b1; cond = (a == b); end
                rvex_pkg::FN_BNE:   begin is_branch = 1'b1; cond = (a != b); end
                rvex_pkg::FN_BLT:   begin
                    is_branch = 1'b1; cond = $signed(a) < $signed(b);
                end
                rvex_pkg::FN_BLTU:  begin is_branch = 1'b1; cond = (a < b); end
                rvex_pkg::FN_BGE:   begin
                    is_branch = 1'b1; cond = !($signed(a) < $signed(b));
                end
                rvex_pkg::FN_BGEU:  begin is_branch = 1'b1; cond = !(a < b); end
                rvex_pkg::FN_JAL:   begin
                    val = arch_pc + rvex_pkg::PC_STEP; writes = 1'b1; taken = 1'b1;
                    nxt = arch_pc + (imm << 1);
                end
                rvex_pkg::FN_JALR:  begin
                    val = arch_pc + rvex_pkg::PC_STEP; writes = 1'b1; taken = 1'b1;
                    nxt = (a + imm) & rvex_pkg::JALR_MASK;
                end
                default: ;
            endcase
            if (is_branch && cond) begin
                taken = 1'b1;
                nxt   = arch_pc + imm;
            end
            if (writes && (req.dest_reg == '0 || req.dest_reg >= rvex_pkg::NUM_REGS_DEF)) begin
                writes = 1'b0;
            end
            if (writes) begin
                arch_regs[req.dest_reg] = val;
            end else begin
                val = '0;
            end
            arch_pc          = nxt;
            rsp.write_value  = val;
            rsp.wrote_reg    = writes;
            rsp.branch_taken = taken;
            rsp.new_pc       = nxt;
            return rsp;
        endfunction

        function void note_request(rvex_pkg::t_ex_req req);
            expected_rsp_q.push_back(execute_instr(req));
        endfunction

        function void log_failure(string msg);
            if (mismatches < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void check_response(rvex_pkg::t_ex_rsp rsp);
            rvex_pkg::t_ex_rsp exp_rsp;
            if (expected_rsp_q.size() == 0) begin
                log_failure($sformatf("response with no request outstanding: %h", rsp));
                return;
            end
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp.write_value !== exp_rsp.write_value ||
                rsp.wrote_reg !== exp_rsp.wrote_reg ||
                rsp.branch_taken !== exp_rsp.branch_taken ||
                rsp.new_pc !== exp_rsp.new_pc) begin
                log_failure($sformatf(
                    "mismatch: value %h/%h wrote %b/%b taken %b/%b pc %h/%h (exp/act)",
                    exp_rsp.write_value, rsp.write_value, exp_rsp.wrote_reg,
                    rsp.wrote_reg, exp_rsp.branch_taken, rsp.branch_taken,
                    exp_rsp.new_pc, rsp.new_pc));
            end
        endfunction

        function int pending_count();
            return expected_rsp_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    rvex_pkg::t_ex_req i_in_req;
    logic              o_out_valid;
    logic              i_out_ready;
    rvex_pkg::t_ex_rsp o_out_rsp;

    exec_scoreboard sb = new();
    bit             quiet = 1'b0;
    int unsigned    cycles = 0;

    rv32i_integer_execute_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("rv32i_integer_execute_unit verification failed");
            $finish;
        end
    end

    // Responses are checked before the request of the same edge is noted;
    // a request never completes in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_response(o_out_rsp);
            if (i_in_valid && o_in_ready) sb.note_request(i_in_req);
        end
    end

    initial begin : out_ready_gen
        int unsigned stall;
        i_out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                stall = $urandom_range(1, 19);
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic rvex_pkg::t_ex_req make_req(logic [FUNC_W-1:0] func, int unsigned rd,
                                                   int unsigned rs1, int unsigned rs2,
                                                   logic [XLEN-1:0] imm);
        rvex_pkg::t_ex_req r;
        r.func      = func;
        r.dest_reg  = rd[IDX_W-1:0];
        r.src1_reg  = rs1[IDX_W-1:0];
        r.src2_reg  = rs2[IDX_W-1:0];
        r.immediate = imm;
        return r;
    endfunction

    // Favor a few low registers so that results feed later instructions.
    function automatic logic [IDX_W-1:0] pick_reg();
        if ($urandom_range(0, 9) < 6) return IDX_W'($urandom_range(0, 7));
        return IDX_W'($urandom_range(0, 31));
    endfunction

    function automatic rvex_pkg::t_ex_req random_req();
        rvex_pkg::t_ex_req r;
        if ($urandom_range(0, 99) < 5) begin
            r.func = FUNC_W'($urandom_range(int'(rvex_pkg::FN_JALR) + 1,
                                            int'(FN_UNUSED_LAST)));
        end else begin
            r.func = FUNC_W'($urandom_range(int'(rvex_pkg::FN_ADD),
                                            int'(rvex_pkg::FN_JALR)));
        end
        r.dest_reg = pick_reg();
        r.src1_reg = pick_reg();
        r.src2_reg = pick_reg();
        case ($urandom_range(0, 3))
            0: r.immediate = $urandom;
            1: r.immediate = 32'($urandom_range(0, 4095)) - 32'd2048;
            2: r.immediate = 32'($urandom_range(0, 63)) * 32'd4 - 32'd128;
            default: begin
                case ($urandom_range(0, 3))
                    0: r.immediate = 32'h0000_0000;
                    1: r.immediate = 32'hFFFF_FFFF;
                    2: r.immediate = 32'h8000_0000;
                    default: r.immediate = 32'h7FFF_FFFF;
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input rvex_pkg::t_ex_req req);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_sender(input int unsigned n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_pause();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        rvex_pkg::t_ex_req prog [$];
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Operand setup: most negative, all ones, most positive, shift amounts.
        prog.push_back(make_req(rvex_pkg::FN_LUI,   1, 0, 0, 32'h8000_0000));
        prog.push_back(make_req(rvex_pkg::FN_ADDI,  2, 0, 0, 32'hFFFF_FFFF));
        prog.push_back(make_req(rvex_pkg::FN_ADDI,  3, 0, 0, 32'h7FFF_FFFF));
        prog.push_back(make_req(rvex_pkg::FN_ADDI,  4, 0, 0, 32'd31));
        // Shift amount of 33 only uses its low five bits.
        prog.push_back(make_req(rvex_pkg::FN_ADDI,  5, 0, 0, 32'd33));
        prog.push_back(make_req(rvex_pkg::FN_ADD,   6, 1, 2, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SUB,   7, 0, 1, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_XOR,   8, 1, 2, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_XORI,  9, 3, 0, 32'h8000_0000));
        prog.push_back(make_req(rvex_pkg::FN_OR,   10, 1, 3, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_ORI,  11, 0, 0, 32'h1234_5678));
        prog.push_back(make_req(rvex_pkg::FN_AND,  12, 2, 3, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_ANDI, 13, 2, 0, 32'hFFFF_F800));
        prog.push_back(make_req(rvex_pkg::FN_SLL,  14, 2, 4, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SRL,  15, 1, 4, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SRA,  16, 1, 5, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SLT,  17, 1, 3, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SLTI, 18, 3, 0, 32'h8000_0000));
        prog.push_back(make_req(rvex_pkg::FN_SLTU, 19, 1, 3, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_SLTIU, 20, 0, 0, 32'hFFFF_FFFF));
        prog.push_back(make_req(rvex_pkg::FN_BEQ,   0, 1, 1, 32'hFFFF_FFF0));
        prog.push_back(make_req(rvex_pkg::FN_BNE,   0, 1, 1, 32'd64));
        prog.push_back(make_req(rvex_pkg::FN_BLT,   0, 1, 3, 32'd12));
        prog.push_back(make_req(rvex_pkg::FN_BLTU,  0, 1, 3, 32'd12));
        prog.push_back(make_req(rvex_pkg::FN_BGE,   0, 3, 1, 32'd8));
        prog.push_back(make_req(rvex_pkg::FN_BGEU,  0, 2, 1, 32'h8000_0000));
        prog.push_back(make_req(rvex_pkg::FN_JAL,  31, 0, 0, 32'h7FFF_FFFF));
        // Link and base register are the same: the old base must be used.
        prog.push_back(make_req(rvex_pkg::FN_JALR,  2, 2, 0, 32'd0));
        prog.push_back(make_req(rvex_pkg::FN_ADDI,  0, 3, 0, 32'd5));
        prog.push_back(make_req(FN_UNUSED_LAST,     6, 1, 2, 32'hFFFF_FFFF));
        foreach (prog[i]) send_request(prog[i]);

        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k == QUIET_FROM) quiet = 1'b1;
            if (k % 500 == 250) drain_pause();
            send_request(random_req());
            if (!quiet && $urandom_range(0, 9) == 0) idle_sender($urandom_range(1, 19));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("rv32i_integer_execute_unit verification clean");
        end else begin
            $display("rv32i_integer_execute_unit verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rvex_pkg.sv
rtl/rvex_regfile.sv
rtl/rvex_alu.sv
rtl/rv32i_integer_execute_unit.sv
tb/rv32i_integer_execute_unit_test.sv
